// File: hdl/rslot_pkg.sv
// rslot_pkg: shared types and constants of the resource slot table
// slot record, command and status codes, controller states, cell controls
// no dependencies
package rslot_pkg;

    localparam int RSLOT_SLOTS   = 32;
    localparam int RSLOT_TRACKED = 256;

    localparam int CAP_W   = 6;
    localparam int KEY_W   = 16;
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;
    localparam logic [KEY_W-1:0] MAX_TYPE  = 16'd255;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_FIND  = 2'd1,
        CMD_ENUM  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINAL
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]  handle;
        logic [KEY_W-1:0]  type_id;
        logic [KEY_W-1:0]  name_id;
        logic [DATA_W-1:0] ref_val;
        logic [DATA_W-1:0] size_val;
    } t_slot;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

// File: hdl/rslot_cell.sv
// rslot_cell: one slot of the table, a stage of the rotating ring
// takes the record of its neighbor on each shift; depends on rslot_pkg
module rslot_cell
    import rslot_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_slot     i_slot,
    output t_slot     o_slot
);

    t_slot r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.handle <= '0;
        end else if (i_ctl.clear) begin
            r_slot.handle <= '0;
        end else if (i_ctl.shift) begin
            r_slot <= i_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

// File: hdl/rslot_ctrl.sv
// rslot_ctrl: command sequencer at the head of the slot ring
// walks the ring once per find, enumerate or add into a non-full table; depends on rslot_pkg
module rslot_ctrl
    import rslot_pkg::*;
#(
    parameter int SLOTS         = RSLOT_SLOTS,
    parameter int TRACKED_TYPES = RSLOT_TRACKED
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CAP_W-1:0]   i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [KEY_W-1:0]   i_type_key,
    input  logic [KEY_W-1:0]   i_name_key,
    input  logic [DATA_W-1:0]  i_payload_ref,
    input  logic [DATA_W-1:0]  i_payload_size,
    input  t_slot              i_head,
    output t_slot              o_head_wb,
    output t_cell_ctl          o_ctl,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [STAT_W-1:0]  o_status,
    output logic [KEY_W-1:0]   o_handle_out,
    output logic [KEY_W-1:0]   o_type_out,
    output logic [DATA_W-1:0]  o_payload_ref_out,
    output logic [DATA_W-1:0]  o_payload_size_out,
    output logic [CAP_W-1:0]   o_type_count,
    output logic               o_last
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TW = $clog2(TRACKED_TYPES);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;
    logic [KEY_W-1:0]  r_tk, n_tk, r_nk, n_nk;
    logic [DATA_W-1:0] r_pr, n_pr, r_ps, n_ps;
    logic [IW-1:0]     r_idx, n_idx;
    logic              r_done, n_done;
    logic [KEY_W-1:0]  r_hit_handle, n_hit_handle;
    logic [DATA_W-1:0] r_hit_ref, n_hit_ref, r_hit_size, n_hit_size;
    t_status           r_fstat, n_fstat;
    logic [CAP_W-1:0]  r_count, n_count;
    logic [TRACKED_TYPES-1:0] r_seen, n_seen;
    logic [CAP_W-1:0]  r_used, n_used;
    logic [KEY_W-1:0]  r_hctr, n_hctr;
    logic [CAP_W-1:0]  r_cap_reg;

    logic              r_out_valid, n_out_valid;
    t_status           r_status, n_status;
    logic [KEY_W-1:0]  r_handle_out, n_handle_out, r_type_out, n_type_out;
    logic [DATA_W-1:0] r_ref_out, n_ref_out, r_size_out, n_size_out;
    logic [CAP_W-1:0]  r_cnt_out, n_cnt_out;
    logic              r_last, n_last;

    logic [CAP_W-1:0] cap;
    logic             adv, in_acc, step, in_cap, full, place, hit, tracked, emit;
    logic [TW-1:0]    seen_idx;

    assign cap     = (r_cap_reg > CAP_W'(SLOTS)) ? CAP_W'(SLOTS) : r_cap_reg;
    assign adv     = !r_out_valid || !i_out_stall;
    assign in_acc  = (r_state == S_IDLE) && i_in_valid;
    assign step    = (r_state == S_SCAN) && adv;
    assign in_cap  = CAP_W'(r_idx) < cap;
    assign full    = r_used >= cap;
    assign place   = step && (r_cmd == CMD_ADD) && in_cap && !r_done
                     && (i_head.handle == '0);
    assign hit     = step && (r_cmd == CMD_FIND) && in_cap && !r_done
                     && (i_head.handle != '0) && (i_head.type_id == r_tk)
                     && (i_head.name_id == r_nk);
    assign tracked = (i_head.type_id <= MAX_TYPE)
                     && (32'(i_head.type_id) < TRACKED_TYPES);
    assign seen_idx = i_head.type_id[TW-1:0];
    assign emit    = step && (r_cmd == CMD_ENUM) && in_cap && (i_head.handle != '0)
                     && tracked && !r_seen[seen_idx];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if ((t_cmd'(i_cmd) == CMD_CLEAR)
                        || ((t_cmd'(i_cmd) == CMD_ADD) && full)) begin
                        n_state = S_FINAL;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (adv && (r_idx == LAST_IDX)) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (adv) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cmd        = r_cmd;
        n_tk         = r_tk;
        n_nk         = r_nk;
        n_pr         = r_pr;
        n_ps         = r_ps;
        n_idx        = r_idx;
        n_done       = r_done;
        n_hit_handle = r_hit_handle;
        n_hit_ref    = r_hit_ref;
        n_hit_size   = r_hit_size;
        n_fstat      = r_fstat;
        n_count      = r_count;
        n_seen       = r_seen;
        n_used       = r_used;
        n_hctr       = r_hctr;
        n_out_valid  = r_out_valid;
        n_status     = r_status;
        n_handle_out = r_handle_out;
        n_type_out   = r_type_out;
        n_ref_out    = r_ref_out;
        n_size_out   = r_size_out;
        n_cnt_out    = r_cnt_out;
        n_last       = r_last;
        o_head_wb    = i_head;
        o_ctl.shift  = step;
        o_ctl.clear  = 1'b0;

        if (adv) begin
            n_out_valid = 1'b0;
        end

        if (in_acc) begin
            n_cmd        = t_cmd'(i_cmd);
            n_tk         = i_type_key;
            n_nk         = i_name_key;
            n_pr         = i_payload_ref;
            n_ps         = i_payload_size;
            n_idx        = '0;
            n_done       = 1'b0;
            n_hit_handle = '0;
            n_hit_ref    = '0;
            n_hit_size   = '0;
            n_count      = '0;
            case (t_cmd'(i_cmd))
                CMD_ADD:   n_fstat = full ? ST_FULL : ST_OK;
                CMD_FIND:  n_fstat = ST_NOTFOUND;
                CMD_ENUM: begin
                    n_fstat = ST_OK;
                    n_seen  = '0;
                end
                CMD_CLEAR: begin
                    n_fstat     = ST_OK;
                    n_used      = '0;
                    n_hctr      = KEY_W'(1);
                    o_ctl.clear = 1'b1;
                end
                default:   n_fstat = ST_OK;
            endcase
        end

        if (step) begin
            n_idx = (r_idx == LAST_IDX) ? '0 : r_idx + IW'(1);
        end

        if (place) begin
            // a drawn handle of zero still leaves the slot reading as free
            o_head_wb.handle   = r_hctr;
            o_head_wb.type_id  = r_tk;
            o_head_wb.name_id  = r_nk;
            o_head_wb.ref_val  = r_pr;
            o_head_wb.size_val = r_ps;
            n_hctr       = r_hctr + KEY_W'(1);
            n_used       = r_used + CAP_W'(1);
            n_done       = 1'b1;
            n_hit_handle = r_hctr;
        end

        if (hit) begin
            n_done       = 1'b1;
            n_fstat      = ST_OK;
            n_hit_handle = i_head.handle;
            n_hit_ref    = i_head.ref_val;
            n_hit_size   = i_head.size_val;
        end

        if (emit) begin
            n_seen[seen_idx] = 1'b1;
            n_count      = r_count + CAP_W'(1);
            n_out_valid  = 1'b1;
            n_status     = ST_OK;
            n_handle_out = '0;
            n_type_out   = i_head.type_id;
            n_ref_out    = '0;
            n_size_out   = '0;
            n_cnt_out    = '0;
            n_last       = 1'b0;
        end

        if ((r_state == S_FINAL) && adv) begin
            n_out_valid  = 1'b1;
            n_status     = r_fstat;
            n_handle_out = r_hit_handle;
            n_type_out   = '0;
            n_ref_out    = r_hit_ref;
            n_size_out   = r_hit_size;
            n_cnt_out    = r_count;
            n_last       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_done      <= 1'b0;
            r_seen      <= '0;
            r_used      <= '0;
            r_hctr      <= KEY_W'(1);
            r_cap_reg   <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_done      <= n_done;
            r_seen      <= n_seen;
            r_used      <= n_used;
            r_hctr      <= n_hctr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cap_reg <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_tk         <= n_tk;
        r_nk         <= n_nk;
        r_pr         <= n_pr;
        r_ps         <= n_ps;
        r_hit_handle <= n_hit_handle;
        r_hit_ref    <= n_hit_ref;
        r_hit_size   <= n_hit_size;
        r_fstat      <= n_fstat;
        r_count      <= n_count;
        r_status     <= n_status;
        r_handle_out <= n_handle_out;
        r_type_out   <= n_type_out;
        r_ref_out    <= n_ref_out;
        r_size_out   <= n_size_out;
        r_cnt_out    <= n_cnt_out;
        r_last       <= n_last;
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_handle_out       = r_handle_out;
    assign o_type_out         = r_type_out;
    assign o_payload_ref_out  = r_ref_out;
    assign o_payload_size_out = r_size_out;
    assign o_type_count       = r_cnt_out;
    assign o_last             = r_last;

    // the ring is only rotated from a full turn's start
    a_idx_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SCAN) |-> (r_idx == '0))
        else $error("scan index not at home outside a scan");

    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (t_cmd'(i_cmd) != CMD_CLEAR) && !((t_cmd'(i_cmd) == CMD_ADD) && full))
        |=> (r_state == S_SCAN))
        else $error("scanning command did not start a scan");

    a_final_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FINAL) && adv) |=> (r_out_valid && r_last))
        else $error("closing item not presented");

    a_add_placed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FINAL) && (r_cmd == CMD_ADD) && (r_fstat == ST_OK)) |-> r_done)
        else $error("add finished without a free slot");

endmodule

// File: hdl/resource_slot_table.sv
// resource_slot_table: top level, a ring of slot cells with a sequencer at its head
// depends on rslot_pkg, rslot_cell and rslot_ctrl
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  input    | i_in_valid / o_in_stall  | i_cmd, i_type_key, i_name_key, i_payload_*
//  result   | o_out_valid / i_out_stall| o_status, o_handle_out, o_type_out, o_payload_*,
//           |                          | o_type_count, o_last
//  config   | i_cfg_we                 | i_cfg_wdata (table capacity)
//
// add, find and enumerate turn the slot ring once, one slot passing the head sequencer per
// cycle while the result register is not stalled
// clear and an add into a full table skip the scan; clear drops all handles at once
// a stalled result register pauses the ring rotation until the item is taken
// synchronous active-low reset; no clearing pass, payload fields of a slot are unset
module resource_slot_table
    import rslot_pkg::*;
#(
    parameter int SLOTS         = RSLOT_SLOTS,
    parameter int TRACKED_TYPES = RSLOT_TRACKED
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CAP_W-1:0]   i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [KEY_W-1:0]   i_type_key,
    input  logic [KEY_W-1:0]   i_name_key,
    input  logic [DATA_W-1:0]  i_payload_ref,
    input  logic [DATA_W-1:0]  i_payload_size,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [STAT_W-1:0]  o_status,
    output logic [KEY_W-1:0]   o_handle_out,
    output logic [KEY_W-1:0]   o_type_out,
    output logic [DATA_W-1:0]  o_payload_ref_out,
    output logic [DATA_W-1:0]  o_payload_size_out,
    output logic [CAP_W-1:0]   o_type_count,
    output logic               o_last
);

    t_slot     cell_q [SLOTS];
    t_slot     head_wb;
    t_cell_ctl ctl;

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++) begin : g_cell
            t_slot cell_d;
            // the last cell closes the ring with the head record, updated on an add
            if (gi == SLOTS - 1) begin : g_tail
                assign cell_d = head_wb;
            end else begin : g_mid
                assign cell_d = cell_q[gi + 1];
            end
            rslot_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_ctl  (ctl),
                .i_slot (cell_d),
                .o_slot (cell_q[gi])
            );
        end
    endgenerate

    rslot_ctrl #(
        .SLOTS        (SLOTS),
        .TRACKED_TYPES(TRACKED_TYPES)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_cmd             (i_cmd),
        .i_type_key        (i_type_key),
        .i_name_key        (i_name_key),
        .i_payload_ref     (i_payload_ref),
        .i_payload_size    (i_payload_size),
        .i_head            (cell_q[0]),
        .o_head_wb         (head_wb),
        .o_ctl             (ctl),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_handle_out      (o_handle_out),
        .o_type_out        (o_type_out),
        .o_payload_ref_out (o_payload_ref_out),
        .o_payload_size_out(o_payload_size_out),
        .o_type_count      (o_type_count),
        .o_last            (o_last)
    );

endmodule

// File: verif/rslot_checker.sv
// rslot_checker: watches both channels and the capacity register of resource_slot_table,
// keeps its own copy of the slot table, predicts every result item and compares it
// depends on rslot_pkg
module rslot_checker
    import rslot_pkg::*;
#(
    parameter int SLOTS         = RSLOT_SLOTS,
    parameter int TRACKED_TYPES = RSLOT_TRACKED
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CAP_W-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [KEY_W-1:0]  i_type_key,
    input  logic [KEY_W-1:0]  i_name_key,
    input  logic [DATA_W-1:0] i_payload_ref,
    input  logic [DATA_W-1:0] i_payload_size,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [STAT_W-1:0] i_status,
    input  logic [KEY_W-1:0]  i_handle_out,
    input  logic [KEY_W-1:0]  i_type_out,
    input  logic [DATA_W-1:0] i_payload_ref_out,
    input  logic [DATA_W-1:0] i_payload_size_out,
    input  logic [CAP_W-1:0]  i_type_count,
    input  logic              i_last,
    output int                o_mismatches,
    output int                o_pending,
    output int                o_results_checked
);

    typedef struct packed {
        t_status           status;
        logic [KEY_W-1:0]  handle;
        logic [KEY_W-1:0]  type_id;
        logic [DATA_W-1:0] ref_val;
        logic [DATA_W-1:0] size_val;
        logic [CAP_W-1:0]  count;
        logic              last;
    } t_slot_result;

    logic [KEY_W-1:0]  tbl_handle [SLOTS];
    logic [KEY_W-1:0]  tbl_type   [SLOTS];
    logic [KEY_W-1:0]  tbl_name   [SLOTS];
    logic [DATA_W-1:0] tbl_ref    [SLOTS];
    logic [DATA_W-1:0] tbl_size   [SLOTS];
    logic [CAP_W-1:0]  live_count;
    logic [KEY_W-1:0]  handle_ctr;
    logic [CAP_W-1:0]  capacity;

    t_slot_result owed_results [$];
    int mismatches = 0;
    int results_checked = 0;

    task automatic drop_all_handles();
        for (int i = 0; i < SLOTS; i++) tbl_handle[i] = '0;
        live_count = '0;
        handle_ctr = 16'd1;
    endtask

    // one command against the shadow table, expected items go to the back of the queue
    task automatic table_command(logic [CMD_W-1:0] op, logic [KEY_W-1:0] tkey,
                                 logic [KEY_W-1:0] nkey, logic [DATA_W-1:0] pref,
                                 logic [DATA_W-1:0] psize);
        int lim;
        int slot;
        int n;
        logic [TRACKED_TYPES-1:0] seen;
        t_slot_result r;
        lim = (capacity > SLOTS) ? SLOTS : capacity;
        r = '0;
        r.status = ST_OK;
        r.last = 1'b1;
        case (op)
            CMD_ADD: begin
                slot = -1;
                if (live_count < lim) begin
                    for (int i = 0; i < lim; i++) begin
                        if (slot < 0 && tbl_handle[i] == '0) slot = i;
                    end
                end
                if (slot < 0) begin
                    r.status = ST_FULL;
                end else begin
                    r.handle = handle_ctr;
                    tbl_handle[slot] = handle_ctr;
                    tbl_type[slot] = tkey;
                    tbl_name[slot] = nkey;
                    tbl_ref[slot] = pref;
                    tbl_size[slot] = psize;
                    handle_ctr = handle_ctr + 16'd1;
                    live_count = live_count + 6'd1;
                end
                owed_results.push_back(r);
            end
            CMD_FIND: begin
                slot = -1;
                for (int i = 0; i < lim; i++) begin
                    if (slot < 0 && tbl_handle[i] != '0 && tbl_type[i] == tkey
                            && tbl_name[i] == nkey) slot = i;
                end
                if (slot < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    r.handle = tbl_handle[slot];
                    r.ref_val = tbl_ref[slot];
                    r.size_val = tbl_size[slot];
                end
                owed_results.push_back(r);
            end
            CMD_ENUM: begin
                seen = '0;
                n = 0;
                r.last = 1'b0;
                for (int i = 0; i < lim; i++) begin
                    // types above the tracked range are skipped
                    if (tbl_handle[i] != '0 && tbl_type[i] <= MAX_TYPE
                            && tbl_type[i] < TRACKED_TYPES && !seen[tbl_type[i]]) begin
                        seen[tbl_type[i]] = 1'b1;
                        r.type_id = tbl_type[i];
                        owed_results.push_back(r);
                        n++;
                    end
                end
                r.type_id = '0;
                r.count = CAP_W'(n);
                r.last = 1'b1;
                owed_results.push_back(r);
            end
            default: begin
                drop_all_handles();
                owed_results.push_back(r);
            end
        endcase
    endtask

    function automatic void check_field(string field, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_result();
        t_slot_result want;
        results_checked++;
        if (owed_results.size() == 0) begin
            $display("%0t: result item with nothing expected, actual status %0h handle %0h",
                     $time, i_status, i_handle_out);
            mismatches++;
        end else begin
            want = owed_results.pop_front();
            check_field("status", DATA_W'(want.status), DATA_W'(i_status));
            check_field("handle_out", DATA_W'(want.handle), DATA_W'(i_handle_out));
            check_field("type_out", DATA_W'(want.type_id), DATA_W'(i_type_out));
            check_field("payload_ref_out", want.ref_val, i_payload_ref_out);
            check_field("payload_size_out", want.size_val, i_payload_size_out);
            check_field("type_count", DATA_W'(want.count), DATA_W'(i_type_count));
            check_field("last", DATA_W'(want.last), DATA_W'(i_last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drop_all_handles();
            capacity = CAP_RESET;
            owed_results.delete();
        end else begin
            if (i_cfg_we) capacity = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) check_result();
            if (i_in_valid && !i_in_stall) begin
                table_command(i_cmd, i_type_key, i_name_key, i_payload_ref, i_payload_size);
            end
        end
        o_pending <= owed_results.size();
        o_mismatches <= mismatches;
        o_results_checked <= results_checked;
    end

endmodule

// File: verif/tb_top.sv
// tb_top: clock, reset, command stimulus and verdict for resource_slot_table
// instantiates the block and rslot_checker beside it; depends on rslot_pkg
module tb_top
    import rslot_pkg::*;
();

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 12;
    localparam int TARGET_ITEMS = 270;
    localparam int LONG_HOLD    = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int SETTLE       = RSLOT_SLOTS + 4;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CAP_W-1:0]  i_cfg_wdata;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [CMD_W-1:0]  i_cmd;
    logic [KEY_W-1:0]  i_type_key;
    logic [KEY_W-1:0]  i_name_key;
    logic [DATA_W-1:0] i_payload_ref;
    logic [DATA_W-1:0] i_payload_size;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [STAT_W-1:0] o_status;
    logic [KEY_W-1:0]  o_handle_out;
    logic [KEY_W-1:0]  o_type_out;
    logic [DATA_W-1:0] o_payload_ref_out;
    logic [DATA_W-1:0] o_payload_size_out;
    logic [CAP_W-1:0]  o_type_count;
    logic              o_last;

    int mismatches;
    int pending;
    int results_checked;

    logic hold_go;
    int items_sent = 0;
    int cap_writes = 0;
    int op_count [4];
    logic [2*KEY_W-1:0] added_keys [$];

    always #(HALF_PERIOD) i_clk = ~i_clk;

    resource_slot_table u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_cmd              (i_cmd),
        .i_type_key         (i_type_key),
        .i_name_key         (i_name_key),
        .i_payload_ref      (i_payload_ref),
        .i_payload_size     (i_payload_size),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_handle_out       (o_handle_out),
        .o_type_out         (o_type_out),
        .o_payload_ref_out  (o_payload_ref_out),
        .o_payload_size_out (o_payload_size_out),
        .o_type_count       (o_type_count),
        .o_last             (o_last)
    );

    rslot_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_cmd              (i_cmd),
        .i_type_key         (i_type_key),
        .i_name_key         (i_name_key),
        .i_payload_ref      (i_payload_ref),
        .i_payload_size     (i_payload_size),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_status           (o_status),
        .i_handle_out       (o_handle_out),
        .i_type_out         (o_type_out),
        .i_payload_ref_out  (o_payload_ref_out),
        .i_payload_size_out (o_payload_size_out),
        .i_type_count       (o_type_count),
        .i_last             (o_last),
        .o_mismatches       (mismatches),
        .o_pending          (pending),
        .o_results_checked  (results_checked)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len(bit gappy);
        int r;
        r = $urandom_range(0, 99);
        if (!gappy || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic logic [KEY_W-1:0] pick_type();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return KEY_W'($urandom_range(0, 15));
        if (r < 7) return KEY_W'($urandom_range(0, 255));
        if (r < 8) return KEY_W'($urandom_range(256, 300));
        return KEY_W'($urandom);
    endfunction

    // caller is right after a rising edge; returns at the edge that took the item, or after the gap behind it
    task automatic send_item(t_cmd op, logic [KEY_W-1:0] tkey, logic [KEY_W-1:0] nkey,
                             logic [DATA_W-1:0] pref, logic [DATA_W-1:0] psize, bit gappy);
        int gap;
        i_in_valid <= 1'b1;
        i_cmd <= op;
        i_type_key <= tkey;
        i_name_key <= nkey;
        i_payload_ref <= pref;
        i_payload_size <= psize;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        op_count[op]++;
        if (op == CMD_ADD) begin
            added_keys.push_back({tkey, nkey});
            if (added_keys.size() > 64) void'(added_keys.pop_front());
        end
        if (op == CMD_CLEAR) added_keys.delete();
        gap = gap_len(gappy);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic random_item(bit gappy);
        t_cmd op;
        logic [KEY_W-1:0] tkey;
        logic [KEY_W-1:0] nkey;
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) op = CMD_ADD;
        else if (r < 78) op = CMD_FIND;
        else if (r < 92) op = CMD_ENUM;
        else op = CMD_CLEAR;
        tkey = pick_type();
        nkey = $urandom_range(0, 1) ? KEY_W'($urandom_range(0, 7)) : KEY_W'($urandom);
        // finds mostly look up keys that were added
        if (op == CMD_FIND && added_keys.size() != 0 && $urandom_range(0, 99) < 65) begin
            {tkey, nkey} = added_keys[$urandom_range(0, added_keys.size() - 1)];
        end
        send_item(op, tkey, nkey, $urandom, $urandom, gappy);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] cap);
        wait_idle();
        // some margin after the last item before the capacity changes
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cap_writes++;
    endtask

    task automatic random_phase(int phase);
        logic [CAP_W-1:0] cap;
        bit gappy;
        case (phase)
            0: cap = 6'd1;
            1: cap = 6'd0;
            2: cap = 6'd2;
            3: cap = 6'd31;
            4: cap = 6'd33;
            5: cap = 6'd63;
            default: cap = CAP_W'($urandom_range(0, 63));
        endcase
        set_capacity(cap);
        gappy = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 2) == 0) send_item(CMD_CLEAR, '0, '0, '0, '0, gappy);
        repeat ($urandom_range(18, 32)) random_item(gappy);
    endtask

    // output side: random stalls, calm stretches, and one long hold-off on request
    initial begin : result_sink
        int hold_left;
        int burst_left;
        int mode_left;
        bit hold_taken;
        bit calm;
        hold_left = 0;
        burst_left = 0;
        mode_left = 0;
        hold_taken = 1'b0;
        calm = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(50, 300);
            end else begin
                mode_left--;
            end
            if (hold_left != 0) hold_left--;
            else if (burst_left != 0) burst_left--;
            else if (!calm) burst_left = gap_len(1'b1);
            i_out_stall <= (hold_left != 0) || (burst_left != 0);
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int phase;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= CAP_RESET;
        i_in_valid <= 1'b0;
        i_cmd <= CMD_ADD;
        i_type_key <= '0;
        i_name_key <= '0;
        i_payload_ref <= '0;
        i_payload_size <= '0;
        hold_go <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, key extremes, duplicates, untracked type, clear
        send_item(CMD_FIND, 16'h0000, 16'h0000, '0, '0, 1'b0);
        send_item(CMD_ENUM, '0, '0, '0, '0, 1'b0);
        send_item(CMD_ADD, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_item(CMD_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_item(CMD_ADD, 16'h00FF, 16'h0001, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1);
        send_item(CMD_ADD, 16'h0100, 16'h0002, 32'h1234_5678, 32'h8765_4321, 1'b0);
        send_item(CMD_ADD, 16'h0000, 16'h0007, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0);
        send_item(CMD_ADD, 16'h00FF, 16'h0001, 32'hDEAD_0001, 32'h0000_0010, 1'b1);
        send_item(CMD_FIND, 16'h0000, 16'h0000, '0, '0, 1'b0);
        send_item(CMD_FIND, 16'hFFFF, 16'hFFFF, '0, '0, 1'b0);
        send_item(CMD_FIND, 16'h00FF, 16'h0001, '0, '0, 1'b0);
        send_item(CMD_FIND, 16'h0000, 16'h0001, '0, '0, 1'b1);
        send_item(CMD_FIND, 16'h0001, 16'h0000, '0, '0, 1'b0);
        send_item(CMD_ENUM, '0, '0, '0, '0, 1'b0);
        send_item(CMD_CLEAR, '0, '0, '0, '0, 1'b0);
        send_item(CMD_FIND, 16'h0000, 16'h0000, '0, '0, 1'b0);
        send_item(CMD_ADD, 16'h0003, 16'h0003, 32'h0000_0003, 32'h0000_0003, 1'b0);
        // zero capacity: adds are full, finds and enumerations match no slot
        set_capacity(6'd0);
        send_item(CMD_ADD, 16'h0004, 16'h0004, '1, '1, 1'b0);
        send_item(CMD_FIND, 16'h0003, 16'h0003, '0, '0, 1'b0);
        send_item(CMD_ENUM, '0, '0, '0, '0, 1'b0);
        set_capacity(6'd1);
        send_item(CMD_CLEAR, '0, '0, '0, '0, 1'b0);
        send_item(CMD_ADD, 16'h0005, 16'h0005, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        send_item(CMD_ADD, 16'h0006, 16'h0006, '0, '0, 1'b0);
        send_item(CMD_FIND, 16'h0005, 16'h0005, '0, '0, 1'b0);
        send_item(CMD_ENUM, '0, '0, '0, '0, 1'b0);

        // every slot holds a distinct tracked type, then overflow and a full enumeration
        set_capacity(6'd63);
        send_item(CMD_CLEAR, '0, '0, '0, '0, 1'b1);
        for (int i = 0; i < RSLOT_SLOTS + 2; i++) begin
            send_item(CMD_ADD, KEY_W'((i * 37) % 256), KEY_W'($urandom), $urandom, $urandom,
                      1'b1);
        end
        send_item(CMD_ENUM, '0, '0, '0, '0, 1'b1);
        repeat (4) random_item(1'b1);

        // output held off while the input keeps offering items
        set_capacity(CAP_RESET);
        hold_go <= 1'b1;
        repeat (30) random_item(1'b0);

        phase = 0;
        while (items_sent < TARGET_ITEMS) begin
            random_phase(phase);
            phase++;
        end

        wait_idle();
        repeat (SETTLE) @(posedge i_clk);
        $display("run covered %0d items (add %0d, find %0d, enum %0d, clear %0d), %0d cap writes",
                 items_sent, op_count[CMD_ADD], op_count[CMD_FIND], op_count[CMD_ENUM],
                 op_count[CMD_CLEAR], cap_writes);
        $display("%0d result items compared, with a full-table enumeration and a %0d-cycle hold",
                 results_checked, LONG_HOLD);
        if (mismatches == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
